@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the slot list checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Consequent must hold at the delay n after the antecedent
`define ASSERT_DELAY(label, clk, rst, ante, n, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error(msg);

`endif

@@ rtl/dlsl_pkg.sv @@
// ----------------------------------------------------------------------------
// dlsl_pkg
// Widths, operation codes and the control store of the slot list sequencer.
// ----------------------------------------------------------------------------
package dlsl_pkg;

  // Table geometry: a pointer is a slot index plus one bit for "no slot"
  localparam int SLOTS  = 256;
  localparam int SLOT_W = 8;
  localparam int PTR_W  = SLOT_W + 1;
  localparam int MODE_W = 3;
  localparam int UPC_W  = 5;

  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(SLOTS);

  typedef logic [UPC_W-1:0] upc_t;

  // Request operations; other codes leave the list as it is
  typedef enum logic [MODE_W-1:0] {
    MODE_PREPEND   = 3'd0,
    MODE_APPEND    = 3'd1,
    MODE_UNLINK    = 3'd2,
    MODE_MOVE_HEAD = 3'd3,
    MODE_MOVE_TAIL = 3'd4
  } mode_t;

  // Previous-link write address and data
  typedef enum logic [1:0] {PA_S, PA_H, PA_N} pa_sel_t;
  typedef enum logic [1:0] {PD_NONE, PD_S, PD_T, PD_P} pd_sel_t;

  // Next-link write address and data
  typedef enum logic [1:0] {NA_S, NA_T, NA_P} na_sel_t;
  typedef enum logic [1:0] {ND_NONE, ND_S, ND_H, ND_N} nd_sel_t;

  // Head and tail register updates
  typedef enum logic [1:0] {H_KEEP, H_S, H_N, H_S_IF_NONE} h_sel_t;
  typedef enum logic [1:0] {T_KEEP, T_S, T_P, T_S_IF_NONE} t_sel_t;

  // Branch conditions
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_S_NE_H,
    C_S_NE_T,
    C_S_EQ_H,
    C_S_EQ_T,
    C_NOP_T,   // head equals tail, or slot is the tail
    C_NOP_H    // head equals tail, or slot is the head
  } cond_t;

  // One control word
  typedef struct packed {
    logic    rd;       // load the slot's links into the link registers
    logic    pwe;
    pa_sel_t pa;
    pd_sel_t pd;
    logic    nwe;
    na_sel_t na;
    nd_sel_t nd;
    h_sel_t  hs;
    t_sel_t  ts;
    cond_t   cond;
    logic    annul;    // drop this word's actions when the branch is taken
    logic    br_exit;  // a taken branch ends the request
    upc_t    tgt;
    logic    last;     // falling through ends the request
  } ucw_t;

  // Control store addresses
  localparam upc_t UA_NOP   = 5'd0;
  localparam upc_t UA_PRE1  = 5'd1;
  localparam upc_t UA_PRE2  = 5'd2;
  localparam upc_t UA_APP1  = 5'd3;
  localparam upc_t UA_APP2  = 5'd4;
  localparam upc_t UA_UN0   = 5'd5;
  localparam upc_t UA_UN1   = 5'd6;
  localparam upc_t UA_UN2   = 5'd7;
  localparam upc_t UA_UN3   = 5'd8;
  localparam upc_t UA_UN4   = 5'd9;
  localparam upc_t UA_UN5   = 5'd10;
  localparam upc_t UA_MT0   = 5'd11;
  localparam upc_t UA_MT1   = 5'd12;
  localparam upc_t UA_MT2   = 5'd13;
  localparam upc_t UA_TFIN  = 5'd14;
  localparam upc_t UA_MTH   = 5'd15;
  localparam upc_t UA_MH0   = 5'd16;
  localparam upc_t UA_MH1   = 5'd17;
  localparam upc_t UA_MH2   = 5'd18;
  localparam upc_t UA_MH3   = 5'd19;
  localparam upc_t UA_HFIN  = 5'd20;
  localparam upc_t UA_MHT   = 5'd21;

  localparam ucw_t UCW_IDLE = '{
    rd: 1'b0, pwe: 1'b0, pa: PA_S, pd: PD_NONE,
    nwe: 1'b0, na: NA_S, nd: ND_NONE,
    hs: H_KEEP, ts: T_KEEP,
    cond: C_NEVER, annul: 1'b0, br_exit: 1'b0, tgt: UA_NOP, last: 1'b0
  };

  // First control word of each operation
  function automatic upc_t entry_pc(logic [MODE_W-1:0] mode);
    upc_t a;
    case (mode)
      MODE_PREPEND:   a = UA_PRE1;
      MODE_APPEND:    a = UA_APP1;
      MODE_UNLINK:    a = UA_UN0;
      MODE_MOVE_HEAD: a = UA_MH0;
      MODE_MOVE_TAIL: a = UA_MT0;
      default:        a = UA_NOP;
    endcase
    return a;
  endfunction

  // Control store. S is the request slot, H/T the head and tail, P/N the
  // slot's previous and next links as last loaded and kept current.
  function automatic ucw_t ucode_rom(upc_t a);
    ucw_t w;
    w = UCW_IDLE;
    case (a)
      UA_NOP: begin
        w.last = 1'b1;
      end
      // prepend: prev[S]=none, next[S]=H; prev[H]=S, H=S, T=S if empty
      UA_PRE1: begin
        w.pwe = 1'b1; w.pa = PA_S; w.pd = PD_NONE;
        w.nwe = 1'b1; w.na = NA_S; w.nd = ND_H;
      end
      UA_PRE2: begin
        w.pwe = 1'b1; w.pa = PA_H; w.pd = PD_S;
        w.hs = H_S; w.ts = T_S_IF_NONE;
        w.last = 1'b1;
      end
      // append: next[S]=none, prev[S]=T; next[T]=S, T=S, H=S if empty
      UA_APP1: begin
        w.nwe = 1'b1; w.na = NA_S; w.nd = ND_NONE;
        w.pwe = 1'b1; w.pa = PA_S; w.pd = PD_T;
      end
      UA_APP2: begin
        w.nwe = 1'b1; w.na = NA_T; w.nd = ND_S;
        w.ts = T_S; w.hs = H_S_IF_NONE;
        w.last = 1'b1;
      end
      // unlink
      UA_UN0: begin
        w.rd = 1'b1;
      end
      UA_UN1: begin
        w.hs = H_N;
        w.pwe = 1'b1; w.pa = PA_N; w.pd = PD_NONE;
        w.cond = C_S_NE_H; w.annul = 1'b1; w.tgt = UA_UN2;
      end
      UA_UN2: begin
        w.ts = T_P;
        w.nwe = 1'b1; w.na = NA_P; w.nd = ND_NONE;
        w.cond = C_S_NE_T; w.annul = 1'b1; w.tgt = UA_UN3;
      end
      UA_UN3: begin
        w.nwe = 1'b1; w.na = NA_P; w.nd = ND_N;
      end
      UA_UN4: begin
        w.pwe = 1'b1; w.pa = PA_N; w.pd = PD_P;
        w.nwe = 1'b1; w.na = NA_S; w.nd = ND_NONE;
      end
      UA_UN5: begin
        w.pwe = 1'b1; w.pa = PA_S; w.pd = PD_NONE;
        w.last = 1'b1;
      end
      // move to tail
      UA_MT0: begin
        w.rd = 1'b1;
        w.cond = C_NOP_T; w.br_exit = 1'b1;
      end
      UA_MT1: begin
        w.nwe = 1'b1; w.na = NA_P; w.nd = ND_N;
        w.cond = C_S_EQ_H; w.annul = 1'b1; w.tgt = UA_MTH;
      end
      UA_MT2: begin
        w.pwe = 1'b1; w.pa = PA_N; w.pd = PD_P;
        w.nwe = 1'b1; w.na = NA_T; w.nd = ND_S;
      end
      UA_TFIN: begin
        w.nwe = 1'b1; w.na = NA_S; w.nd = ND_NONE;
        w.pwe = 1'b1; w.pa = PA_S; w.pd = PD_T;
        w.ts = T_S;
        w.last = 1'b1;
      end
      UA_MTH: begin
        w.hs = H_N;
        w.pwe = 1'b1; w.pa = PA_N; w.pd = PD_NONE;
        w.nwe = 1'b1; w.na = NA_T; w.nd = ND_S;
        w.cond = C_ALWAYS; w.tgt = UA_TFIN;
      end
      // move to head
      UA_MH0: begin
        w.rd = 1'b1;
        w.cond = C_NOP_H; w.br_exit = 1'b1;
      end
      UA_MH1: begin
        w.nwe = 1'b1; w.na = NA_P; w.nd = ND_N;
        w.cond = C_S_EQ_T; w.tgt = UA_MHT;
      end
      UA_MH2: begin
        w.pwe = 1'b1; w.pa = PA_N; w.pd = PD_P;
      end
      UA_MH3: begin
        w.pwe = 1'b1; w.pa = PA_H; w.pd = PD_S;
      end
      UA_HFIN: begin
        w.pwe = 1'b1; w.pa = PA_S; w.pd = PD_NONE;
        w.nwe = 1'b1; w.na = NA_S; w.nd = ND_H;
        w.hs = H_S;
        w.last = 1'b1;
      end
      UA_MHT: begin
        w.ts = T_P;
        w.pwe = 1'b1; w.pa = PA_H; w.pd = PD_S;
        w.cond = C_ALWAYS; w.tgt = UA_HFIN;
      end
      default: begin
        w.last = 1'b1;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/dlsl_req_if.sv @@
// ----------------------------------------------------------------------------
// dlsl_req_if
// Request channel: operation and slot, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlsl_req_if import dlsl_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, mode, slot, input ready);
  modport sink   (input valid, mode, slot, output ready);

endinterface

@@ rtl/dlsl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// dlsl_rsp_if
// Response channel: head and tail after a request, valid/ready handshake.
// ----------------------------------------------------------------------------
interface dlsl_rsp_if import dlsl_pkg::*; ();

  logic             valid;
  logic             ready;
  logic [PTR_W-1:0] head_slot;
  logic [PTR_W-1:0] tail_slot;

  modport source (output valid, head_slot, tail_slot, input ready);
  modport sink   (input valid, head_slot, tail_slot, output ready);

endinterface

@@ rtl/doubly_linked_slot_list.sv @@
// ----------------------------------------------------------------------------
// doubly_linked_slot_list
// Sequencing: each request runs the control program of its operation up to
//   a registered response (unlink is the longest at 6 words); a new request
//   is taken only once the last one ends. The link memories take one write
//   each per cycle, so each link update is a control step of its own.
// Reset: head and tail read as empty, sequencer idle; link memories are not
//   cleared and hold no meaning until a slot is inserted.
// ----------------------------------------------------------------------------
module doubly_linked_slot_list import dlsl_pkg::*; (
  input logic        clk,
  input logic        rst,
  dlsl_req_if.sink   req,
  dlsl_rsp_if.source rsp
);

  // Link memories
  logic [PTR_W-1:0] prev_mem [SLOTS];
  logic [PTR_W-1:0] next_mem [SLOTS];

  // Sequencer and datapath registers
  logic              busy;
  upc_t              upc;
  logic [SLOT_W-1:0] cur_slot;
  logic [PTR_W-1:0]  head_ptr;
  logic [PTR_W-1:0]  tail_ptr;
  logic [PTR_W-1:0]  prev_rd;
  logic [PTR_W-1:0]  next_rd;
  logic              out_valid;
  logic [PTR_W-1:0]  out_head;
  logic [PTR_W-1:0]  out_tail;

  ucw_t             uw;
  logic [PTR_W-1:0] s_ptr;
  logic             taken;
  logic             exiting;
  logic             out_free;
  logic             fire;
  logic             act;
  logic             accept;
  logic [PTR_W-1:0] pa;
  logic [PTR_W-1:0] pd;
  logic [PTR_W-1:0] na;
  logic [PTR_W-1:0] nd;
  logic             pwe;
  logic             nwe;
  logic [PTR_W-1:0] head_next;
  logic [PTR_W-1:0] tail_next;
  upc_t             upc_next;

  assign uw     = ucode_rom(upc);
  assign s_ptr  = {1'b0, cur_slot};
  assign accept = req.valid && !busy;

  // Branch condition
  always_comb begin
    case (uw.cond)
      C_NEVER:  taken = 1'b0;
      C_ALWAYS: taken = 1'b1;
      C_S_NE_H: taken = (s_ptr != head_ptr);
      C_S_NE_T: taken = (s_ptr != tail_ptr);
      C_S_EQ_H: taken = (s_ptr == head_ptr);
      C_S_EQ_T: taken = (s_ptr == tail_ptr);
      C_NOP_T:  taken = (head_ptr == tail_ptr) || (s_ptr == tail_ptr);
      C_NOP_H:  taken = (head_ptr == tail_ptr) || (s_ptr == head_ptr);
      default:  taken = 1'b0;
    endcase
  end

  // Sequencing: hold the final word until the response register is free
  assign out_free = !out_valid || rsp.ready;
  assign exiting  = busy && (taken ? uw.br_exit : uw.last);
  assign fire     = busy && (!exiting || out_free);
  assign act      = fire && !(uw.annul && taken);
  assign upc_next = (taken && !uw.br_exit) ? uw.tgt : upc_t'(upc + 1'b1);

  // Link write address and data
  always_comb begin
    case (uw.pa)
      PA_S:    pa = s_ptr;
      PA_H:    pa = head_ptr;
      PA_N:    pa = next_rd;
      default: pa = s_ptr;
    endcase
    case (uw.pd)
      PD_NONE: pd = NONE_PTR;
      PD_S:    pd = s_ptr;
      PD_T:    pd = tail_ptr;
      PD_P:    pd = prev_rd;
      default: pd = NONE_PTR;
    endcase
    case (uw.na)
      NA_S:    na = s_ptr;
      NA_T:    na = tail_ptr;
      NA_P:    na = prev_rd;
      default: na = s_ptr;
    endcase
    case (uw.nd)
      ND_NONE: nd = NONE_PTR;
      ND_S:    nd = s_ptr;
      ND_H:    nd = head_ptr;
      ND_N:    nd = next_rd;
      default: nd = NONE_PTR;
    endcase
  end

  // Drop writes through an empty link
  assign pwe = act && uw.pwe && !pa[PTR_W-1];
  assign nwe = act && uw.nwe && !na[PTR_W-1];

  // Head and tail updates
  always_comb begin
    head_next = head_ptr;
    tail_next = tail_ptr;
    if (act) begin
      case (uw.hs)
        H_S:         head_next = s_ptr;
        H_N:         head_next = next_rd;
        H_S_IF_NONE: head_next = (head_ptr == NONE_PTR) ? s_ptr : head_ptr;
        default:     head_next = head_ptr;
      endcase
      case (uw.ts)
        T_S:         tail_next = s_ptr;
        T_P:         tail_next = prev_rd;
        T_S_IF_NONE: tail_next = (tail_ptr == NONE_PTR) ? s_ptr : tail_ptr;
        default:     tail_next = tail_ptr;
      endcase
    end
  end

  // Control registers and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      upc       <= UA_NOP;
      head_ptr  <= NONE_PTR;
      tail_ptr  <= NONE_PTR;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        upc  <= entry_pc(req.mode);
      end else if (fire) begin
        if (exiting) begin
          busy <= 1'b0;
        end else begin
          upc <= upc_next;
        end
      end
      head_ptr <= head_next;
      tail_ptr <= tail_next;
      if (fire && exiting) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request slot and response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_slot <= req.slot;
    end
    if (fire && exiting) begin
      out_head <= head_next;
      out_tail <= tail_next;
    end
  end

  // Previous-link memory; read register tracks later writes to the slot
  always_ff @(posedge clk) begin
    if (pwe) begin
      prev_mem[pa[SLOT_W-1:0]] <= pd;
    end
    if (act && uw.rd) begin
      prev_rd <= prev_mem[cur_slot];
    end else if (pwe && (pa == s_ptr)) begin
      prev_rd <= pd;
    end
  end

  // Next-link memory; read register tracks later writes to the slot
  always_ff @(posedge clk) begin
    if (nwe) begin
      next_mem[na[SLOT_W-1:0]] <= nd;
    end
    if (act && uw.rd) begin
      next_rd <= next_mem[cur_slot];
    end else if (nwe && (na == s_ptr)) begin
      next_rd <= nd;
    end
  end

  assign req.ready     = !busy;
  assign rsp.valid     = out_valid;
  assign rsp.head_slot = out_head;
  assign rsp.tail_slot = out_tail;

endmodule

@@ rtl/dlsl_chk.sv @@
// ----------------------------------------------------------------------------
// dlsl_chk
// Port-level checks on the slot list, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dlsl_chk import dlsl_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic [MODE_W-1:0] req_mode,
  input logic [SLOT_W-1:0] req_slot,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [PTR_W-1:0]  head_slot,
  input logic [PTR_W-1:0]  tail_slot
);

  // Stalled response holds
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(head_slot) && $stable(tail_slot), "response changed while stalled")

  // One request in flight: accepting closes the request side
  `ASSERT_NEXT(a_one_inflight, clk, rst, req_valid && req_ready, !req_ready, "request taken while another is in flight")

  // Finishing a request always leaves a response behind
  `ASSERT_IMPL(a_done_has_rsp, clk, rst, $rose(req_ready), rsp_valid, "request finished without a response")

  // A prepend on an idle response side puts the slot at the head
  `ASSERT_DELAY(a_prepend_head, clk, rst, req_valid && req_ready && (req_mode == MODE_PREPEND) && !rsp_valid, 3, rsp_valid && !head_slot[PTR_W-1] && (head_slot[SLOT_W-1:0] == $past(req_slot, 3)), "prepended slot is not the head")

endmodule

bind doubly_linked_slot_list dlsl_chk u_dlsl_chk (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .req_mode  (req.mode),
  .req_slot  (req.slot),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .head_slot (rsp.head_slot),
  .tail_slot (rsp.tail_slot)
);

@@ bench/tb_doubly_linked_slot_list.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_doubly_linked_slot_list
// Drives insert, unlink and move requests into the slot list and checks the
// head and tail returned for each one. The bench keeps its own copy of the
// table of links and applies every accepted request to it. Stimulus is a
// short directed list of corner cases, then long runs of well-formed list
// traffic, then a tail of broken requests such as double inserts.
// ----------------------------------------------------------------------------
module tb_doubly_linked_slot_list;
  import dlsl_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1700;
  localparam int BROKEN_ITEMS = 170;
  localparam int FILL_ITEMS   = 480;
  localparam int MAX_REPORTS  = 10;
  localparam int DRAIN_CYCLES = 16;
  localparam int TIMEOUT_NS   = 3_000_000;

  // Codes with no operation behind them
  localparam logic [MODE_W-1:0] SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] SPARE_LAST  = 3'd7;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SLOT_W-1:0] slot;
  } pend_req_t;

  typedef struct packed {
    ptr_t head;
    ptr_t tail;
  } ends_t;

  logic clk;
  logic rst;

  dlsl_req_if req_ch ();
  dlsl_rsp_if rsp_ch ();

  doubly_linked_slot_list u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Requests waiting to be driven and head/tail pairs waiting to come back
  pend_req_t pending_reqs[$];
  ends_t     want_ends[$];
  ends_t     want;

  // Predicted list state
  ptr_t lst_head;
  ptr_t lst_tail;
  ptr_t prev_of[SLOTS];
  ptr_t next_of[SLOTS];

  // Order of the list as the generator believes it stands
  int order[$];
  bit in_list[SLOTS];
  bit written[SLOTS];
  int used_slots[$];
  int longest;

  // Handshake bookkeeping between the sampling and driving edges
  bit req_taken;
  bit rsp_taken;
  int req_hold;
  int rsp_hold;
  int req_run;
  int rsp_run;

  int failures;
  int n_requests;
  int n_checked;
  int gen_count;

  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic void set_prev_of(ptr_t p, ptr_t v);
    if (p < SLOTS) prev_of[p[SLOT_W-1:0]] = v;
  endfunction

  function automatic void set_next_of(ptr_t p, ptr_t v);
    if (p < SLOTS) next_of[p[SLOT_W-1:0]] = v;
  endfunction

  // Apply one request to the predicted list; links are re-read at every
  // step so that self-referencing links behave as the block does
  function automatic void advance_list(logic [MODE_W-1:0] m, logic [SLOT_W-1:0] s);
    ptr_t sp;
    sp = ptr_t'(s);
    case (m)
      MODE_PREPEND: begin
        prev_of[s] = NONE_PTR;
        next_of[s] = lst_head;
        if (lst_tail == NONE_PTR) lst_tail = sp;
        set_prev_of(lst_head, sp);
        lst_head = sp;
      end
      MODE_APPEND: begin
        next_of[s] = NONE_PTR;
        prev_of[s] = lst_tail;
        if (lst_head == NONE_PTR) lst_head = sp;
        set_next_of(lst_tail, sp);
        lst_tail = sp;
      end
      MODE_UNLINK: begin
        if (sp == lst_head) begin
          lst_head = next_of[s];
          set_prev_of(next_of[s], NONE_PTR);
        end
        if (sp == lst_tail) begin
          lst_tail = prev_of[s];
          set_next_of(prev_of[s], NONE_PTR);
        end
        set_next_of(prev_of[s], next_of[s]);
        set_prev_of(next_of[s], prev_of[s]);
        prev_of[s] = NONE_PTR;
        next_of[s] = NONE_PTR;
      end
      MODE_MOVE_TAIL: begin
        if (lst_head != lst_tail) begin
          if (sp == lst_head) begin
            lst_head = next_of[s];
            set_prev_of(next_of[s], NONE_PTR);
            set_next_of(lst_tail, sp);
            next_of[s] = NONE_PTR;
            prev_of[s] = lst_tail;
            lst_tail = sp;
          end else if (sp != lst_tail) begin
            set_next_of(prev_of[s], next_of[s]);
            set_prev_of(next_of[s], prev_of[s]);
            set_next_of(lst_tail, sp);
            next_of[s] = NONE_PTR;
            prev_of[s] = lst_tail;
            lst_tail = sp;
          end
        end
      end
      MODE_MOVE_HEAD: begin
        if (lst_head != lst_tail && sp != lst_head) begin
          if (sp == lst_tail) begin
            set_next_of(prev_of[s], next_of[s]);
            lst_tail = prev_of[s];
          end else begin
            set_next_of(prev_of[s], next_of[s]);
            set_prev_of(next_of[s], prev_of[s]);
          end
          set_prev_of(lst_head, sp);
          prev_of[s] = NONE_PTR;
          next_of[s] = lst_head;
          lst_head = sp;
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic void drop_from_order(int s);
    for (int i = 0; i < order.size(); i++) begin
      if (order[i] == s) begin
        order.delete(i);
        break;
      end
    end
    in_list[s] = 1'b0;
  endfunction

  // Queue one request and track the list order it should leave behind
  function automatic void add_request(logic [MODE_W-1:0] m, int s);
    pending_reqs.push_back('{mode: m, slot: SLOT_W'(s)});
    gen_count++;
    if ((m == MODE_PREPEND || m == MODE_APPEND) && !written[s]) begin
      written[s] = 1'b1;
      used_slots.push_back(s);
    end
    case (m)
      MODE_PREPEND: begin
        if (!in_list[s]) begin
          order.push_front(s);
          in_list[s] = 1'b1;
        end
      end
      MODE_APPEND: begin
        if (!in_list[s]) begin
          order.push_back(s);
          in_list[s] = 1'b1;
        end
      end
      MODE_UNLINK: drop_from_order(s);
      // A move of a detached slot on a list of two or more inserts it
      MODE_MOVE_HEAD: begin
        if (order.size() >= 2) begin
          drop_from_order(s);
          order.push_front(s);
          in_list[s] = 1'b1;
        end
      end
      MODE_MOVE_TAIL: begin
        if (order.size() >= 2) begin
          drop_from_order(s);
          order.push_back(s);
          in_list[s] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (order.size() > longest) longest = order.size();
  endfunction

  function automatic int pick_member();
    return order[$urandom_range(0, order.size() - 1)];
  endfunction

  function automatic int pick_outsider();
    int s;
    do s = $urandom_range(0, SLOTS - 1); while (in_list[s]);
    return s;
  endfunction

  // One request that keeps the list consistent, steering its length
  // toward the target
  function automatic void add_wellformed(int target);
    int n, r, x, s, p_ins, p_unl;
    logic [MODE_W-1:0] m;
    n = order.size();
    r = $urandom_range(0, 99);
    if (r < 4) begin
      add_request(SPARE_FIRST + MODE_W'($urandom_range(0, 2)), $urandom_range(0, SLOTS - 1));
      return;
    end
    // Unlink or move a slot that was inserted once and is detached now
    if (r < 9 && used_slots.size() != 0) begin
      for (int t = 0; t < 8; t++) begin
        s = used_slots[$urandom_range(0, used_slots.size() - 1)];
        if (!in_list[s]) begin
          add_request(MODE_UNLINK + MODE_W'($urandom_range(0, 2)), s);
          return;
        end
      end
    end
    p_ins = (n < target) ? 60 : 15;
    p_unl = (n > target) ? 60 : 15;
    if (n == SLOTS) p_ins = 0;
    x = $urandom_range(0, 99);
    if (n == 0 || x < p_ins) begin
      m = $urandom_range(0, 1) ? MODE_PREPEND : MODE_APPEND;
      add_request(m, pick_outsider());
    end else if (x < p_ins + p_unl) begin
      add_request(MODE_UNLINK, pick_member());
    end else begin
      // Favor the ends so the head and tail special cases come up often
      case ($urandom_range(0, 2))
        0:       s = order[0];
        1:       s = order[n - 1];
        default: s = pick_member();
      endcase
      m = $urandom_range(0, 1) ? MODE_MOVE_HEAD : MODE_MOVE_TAIL;
      add_request(m, s);
    end
  endfunction

  // Any code; links are read only from slots that were inserted once
  function automatic void add_broken();
    logic [MODE_W-1:0] m;
    int s;
    m = MODE_W'($urandom_range(0, 7));
    if (m == MODE_UNLINK || m == MODE_MOVE_HEAD || m == MODE_MOVE_TAIL)
      s = used_slots[$urandom_range(0, used_slots.size() - 1)];
    else if (order.size() != 0 && $urandom_range(0, 2) == 0)
      s = pick_member();
    else
      s = $urandom_range(0, SLOTS - 1);
    add_request(m, s);
  endfunction

  // Idle length for the next request or response, with occasional
  // stretches of back-to-back traffic
  function automatic int draw_wait(inout int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      run_left = $urandom_range(20, 60);
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  function automatic void report_fail(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // ---------------------------------------------------------------- driver
  always @(negedge clk) begin : req_drive
    bit free;
    if (!rst) begin
      free = !req_ch.valid || req_taken;
      if (req_taken) begin
        req_taken = 1'b0;
        pending_reqs.delete(0);
        req_hold = draw_wait(req_run);
      end
      if (free) begin
        if (req_hold > 0) begin
          req_hold--;
          req_ch.valid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          req_ch.valid <= 1'b1;
          req_ch.mode  <= pending_reqs[0].mode;
          req_ch.slot  <= pending_reqs[0].slot;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Hold ready low for a drawn number of cycles after each response
  always @(negedge clk) begin
    if (!rst) begin
      if (rsp_taken) begin
        rsp_taken = 1'b0;
        rsp_hold = draw_wait(rsp_run);
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        advance_list(req_ch.mode, req_ch.slot);
        want_ends.push_back('{head: lst_head, tail: lst_tail});
        req_taken = 1'b1;
        n_requests++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        rsp_taken = 1'b1;
        if (want_ends.size() == 0) begin
          report_fail($sformatf("response head=%0d tail=%0d with no request outstanding",
                                rsp_ch.head_slot, rsp_ch.tail_slot));
        end else begin
          want = want_ends.pop_front();
          n_checked++;
          if (rsp_ch.head_slot !== want.head || rsp_ch.tail_slot !== want.tail)
            report_fail($sformatf("response %0d: head exp %0d got %0d, tail exp %0d got %0d",
                                  n_checked, want.head, rsp_ch.head_slot,
                                  want.tail, rsp_ch.tail_slot));
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    int seg_len, target;
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.mode  = MODE_PREPEND;
    req_ch.slot  = '0;
    rsp_ch.ready = 1'b0;
    lst_head = NONE_PTR;
    lst_tail = NONE_PTR;
    foreach (prev_of[i]) begin
      prev_of[i] = '0;
      next_of[i] = '0;
    end

    // Spare codes on an empty list, then moves on a one-slot list and an empty one
    add_request(SPARE_FIRST, 0);
    add_request(SPARE_LAST, SLOTS - 1);
    add_request(MODE_PREPEND, 0);
    add_request(MODE_MOVE_HEAD, 0);
    add_request(MODE_MOVE_TAIL, 0);
    add_request(MODE_UNLINK, 0);
    add_request(MODE_MOVE_HEAD, 0);
    add_request(MODE_MOVE_TAIL, 0);
    // Build a four-entry list from both ends
    add_request(MODE_APPEND, SLOTS - 1);
    add_request(MODE_PREPEND, 0);
    add_request(MODE_APPEND, 170);
    add_request(MODE_PREPEND, 85);
    // Moves that do nothing, end-to-end moves, middle moves
    add_request(MODE_MOVE_HEAD, 85);
    add_request(MODE_MOVE_TAIL, 170);
    add_request(MODE_MOVE_TAIL, 85);
    add_request(MODE_MOVE_HEAD, 85);
    add_request(MODE_MOVE_HEAD, SLOTS - 1);
    add_request(MODE_MOVE_TAIL, 85);
    // Unlink from the middle, head and tail down to empty, then unlink a detached slot
    add_request(MODE_UNLINK, 0);
    add_request(MODE_UNLINK, SLOTS - 1);
    add_request(MODE_UNLINK, 85);
    add_request(SPARE_FIRST, 170);
    add_request(MODE_UNLINK, 170);
    add_request(MODE_APPEND, 1);
    add_request(MODE_UNLINK, 0);

    // Fill toward a full table, then wander between lengths, then broken requests
    gen_count = 0;
    while (gen_count < FILL_ITEMS) add_wellformed(SLOTS);
    while (gen_count < RANDOM_ITEMS - BROKEN_ITEMS) begin
      seg_len = $urandom_range(40, 120);
      case ($urandom_range(0, 4))
        0, 1:    target = $urandom_range(0, 3);
        2, 3:    target = $urandom_range(4, 32);
        default: target = $urandom_range(33, SLOTS);
      endcase
      for (int i = 0; i < seg_len; i++) add_wellformed(target);
    end
    while (gen_count < RANDOM_ITEMS) add_broken();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0) @(posedge clk);
    while (want_ends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d requests, checked %0d responses, %0d mismatches",
             n_requests, n_checked, failures);
    $display("List grew to %0d slots; %0d distinct slots were inserted",
             longest, used_slots.size());
    if (failures == 0) begin
      $display("PASS doubly_linked_slot_list");
    end else begin
      $display("FAIL doubly_linked_slot_list");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #TIMEOUT_NS;
    $display("Timeout with %0d requests pending, %0d responses outstanding",
             pending_reqs.size(), want_ends.size());
    $display("FAIL doubly_linked_slot_list");
    $finish;
  end

endmodule
